[rtl/core/jdc_pkg.sv]
// Shared types and constants for the Julian day to calendar converter.
// Depends on nothing; every other file of the block imports it.

package jdc_pkg;

	// Input field widths
	localparam int DAY_BITS  = 25;
	localparam int FRAC_BITS = 32;

	// Output field widths
	localparam int YEAR_W   = 17;
	localparam int MONTH_W  = 4;
	localparam int MDAY_W   = 5;
	localparam int WDAY_W   = 3;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SEC_W    = 22;
	localparam int SEC_FRAC = 16;

	// Calendar constants
	localparam int EPOCH_OFFSET  = 32045;
	localparam int DAYS_400Y     = 146097;
	localparam int DAYS_4Y       = 1461;
	localparam int DAYS_5M       = 153;
	localparam int YEAR_SHIFT    = 4800;
	localparam int CENTURY_YEARS = 100;
	localparam int WEEK_DAYS     = 7;

	// Time of day constants
	localparam int HOURS   = 24;
	localparam int MINUTES = 60;
	localparam int SEC_MAX = MINUTES * (2 ** SEC_FRAC) - 1;

	typedef logic signed [DAY_BITS-1:0] day_num_t;
	typedef logic [FRAC_BITS-1:0]       day_frac_t;
	typedef logic signed [YEAR_W-1:0]   year_t;
	typedef logic [MONTH_W-1:0]         month_t;
	typedef logic [MDAY_W-1:0]          mday_t;
	typedef logic [WDAY_W-1:0]          wday_t;
	typedef logic [HOUR_W-1:0]          hour_t;
	typedef logic [MINUTE_W-1:0]        minute_t;
	typedef logic [SEC_W-1:0]           sec_t;

	typedef struct packed {
		hour_t   hour;
		minute_t minute;
		sec_t    seconds_fixed;
	} tod_t;

endpackage

[rtl/core/jdc_if.sv]
// Request and response channels of the Julian day to calendar converter.
// Depends on jdc_pkg for the payload types.

interface jdc_req_if;
	import jdc_pkg::*;

	logic      valid;
	logic      ready;
	day_num_t  day_number;
	day_frac_t day_fraction;

	modport source (output valid, output day_number, output day_fraction, input ready);
	modport sink   (input valid, input day_number, input day_fraction, output ready);
endinterface

interface jdc_rsp_if;
	import jdc_pkg::*;

	logic    valid;
	logic    ready;
	year_t   year;
	month_t  month;
	mday_t   day_of_month;
	wday_t   weekday;
	hour_t   hour;
	minute_t minute;
	sec_t    seconds_fixed;

	modport source (output valid, output year, output month, output day_of_month,
		output weekday, output hour, output minute, output seconds_fixed, input ready);
	modport sink   (input valid, input year, input month, input day_of_month,
		input weekday, input hour, input minute, input seconds_fixed, output ready);
endinterface

[rtl/core/jdc_tod.sv]
// Three-stage splitter of a day fraction into hour, minute and seconds.
// Depends on jdc_pkg; advanced by the top level's pipeline enable.

module jdc_tod (
	input  logic               clk,
	input  logic               en,
	input  jdc_pkg::day_frac_t frac,
	output jdc_pkg::tod_t      tod
);
	import jdc_pkg::*;

	localparam int P24_W = FRAC_BITS + HOUR_W;
	localparam int P60_W = FRAC_BITS + MINUTE_W;

	logic [P24_W-1:0]     p24;
	logic [P60_W-1:0]     pmin;
	logic [P60_W-1:0]     psec;
	hour_t                hour_s1, hour_s2, hour_s3;
	minute_t              minute_s2, minute_s3;
	logic [FRAC_BITS-1:0] rem_s1, rem_s2;
	sec_t                 sec_s3;

	// Scale by 24, 60 and 60; the integer part peels off at each step
	assign p24  = P24_W'(frac) * P24_W'(HOURS);
	assign pmin = P60_W'(rem_s1) * P60_W'(MINUTES);
	assign psec = P60_W'(rem_s2) * P60_W'(MINUTES);

	always_ff @(posedge clk) begin
		if (en) begin
			hour_s1   <= p24[FRAC_BITS +: HOUR_W];
			rem_s1    <= p24[FRAC_BITS-1:0];
			hour_s2   <= hour_s1;
			minute_s2 <= pmin[FRAC_BITS +: MINUTE_W];
			rem_s2    <= pmin[FRAC_BITS-1:0];
			hour_s3   <= hour_s2;
			minute_s3 <= minute_s2;
			// keep 16 fraction bits of the seconds, truncating the rest
			sec_s3    <= psec[FRAC_BITS-SEC_FRAC +: SEC_W];
		end
	end

	assign tod = '{hour: hour_s3, minute: minute_s3, seconds_fixed: sec_s3};

endmodule

[rtl/core/julian_day_to_calendar.sv]
// Julian day number to proleptic Gregorian date, weekday and time of day.
// Depends on jdc_pkg, jdc_req_if / jdc_rsp_if and jdc_tod.
//
// One request per clock cycle is taken unless the output stalls. The pipeline
// is the chain of divisions by calendar constants (400-year cycle, 4-year
// cycle, 5-month block, day), each done as a reciprocal multiply followed by
// a remainder step, one register stage apiece. The whole pipeline holds while
// the output register carries a result that is not taken, so ready falls only
// under a stall of the response side. Day numbers of zero or below give an
// all-zero result.

module julian_day_to_calendar (
	input  logic             clk,
	input  logic             arst_n,
	jdc_req_if.sink          req,
	jdc_rsp_if.source        rsp
);
	import jdc_pkg::*;

	localparam int NSTAGE  = 12;
	localparam int T1W     = DAY_BITS + 2;
	localparam int Q1W     = T1W - 17;
	localparam int R1W     = 18;
	localparam int R1RAW_W = 19;
	localparam int C100W   = Q1W + 7;
	localparam int YCW     = (Q1W + 9 > YEAR_W) ? Q1W + 9 : YEAR_W;
	localparam int M7W     = DAY_BITS - 2;
	localparam int WRW     = 4;

	// Reciprocals: floor ones are followed by a correction step, the
	// rounded-up ones are exact over the ranges they see
	localparam logic [Q1W-1:0] M1 = Q1W'((64'd1 << T1W) / DAYS_400Y);
	localparam logic [M7W-1:0] M7 = M7W'((64'd1 << DAY_BITS) / WEEK_DAYS);
	localparam int             K2 = 28;
	localparam logic [17:0]    M2 = 18'(((64'd1 << K2) + DAYS_4Y - 1) / DAYS_4Y);
	localparam int             K3 = 18;
	localparam logic [10:0]    M3 = 11'(((64'd1 << K3) + DAYS_5M - 1) / DAYS_5M);
	localparam int             K5 = 10;
	localparam logic [7:0]     M5 = 8'(((64'd1 << K5) + 4) / 5);
	localparam int             T1_BIAS     = EPOCH_OFFSET * 4 - 1;
	localparam int             MONTH_WRAP  = 10;
	localparam int             MARCH_FIRST = 3;

	typedef struct packed {
		logic  pos;
		wday_t weekday;
		tod_t  tod;
	} side_t;

	logic              en;
	logic [NSTAGE-1:0] vld_q;

	logic [DAY_BITS-2:0] mag;
	logic                pos_n;
	tod_t                tod_s3;

	logic                 pos_s1, pos_s2, pos_s3;
	logic [T1W-1:0]       t1_s1, t1_s2, t1_s3;
	logic [DAY_BITS-1:0]  wx_s1, wx_s2;
	logic [Q1W-1:0]       qe1_s2, qe1_s3, qe1_s4;
	logic [M7W-1:0]       wq_s2;
	logic [T1W-1:0]       prod1_s3;
	logic [WRW-1:0]       wr_s3;
	logic [R1RAW_W-1:0]   r1raw_s4;
	logic [Q1W-1:0]       century_s5;
	logic [R1W-1:0]       r1_s5;
	logic [6:0]           q2_s6;
	logic [R1W-1:0]       t2_s6;
	logic [C100W-1:0]     c100_s6, yb_s7, yb_s8, yb_s9, yb_s10;
	logic [10:0]          r2_s7, t3_s8, t3_s9;
	logic [3:0]           q3_s9, q3_s10;
	logic [7:0]           r3_s10;
	mday_t                day_s11;
	month_t               month_s11;
	logic signed [YCW-1:0] yr_s11;
	side_t                side_s4, side_s5, side_s6, side_s7, side_s8;
	side_t                side_s9, side_s10, side_s11;

	year_t   year_s12;
	month_t  month_s12;
	mday_t   mday_s12;
	wday_t   wday_s12;
	tod_t    tod_s12;

	logic [T1W+Q1W-1:0]      p1;
	logic [DAY_BITS+M7W-1:0] pw;
	logic [DAY_BITS-1:0]     wr_full;
	logic [T1W-1:0]          r1_full;
	logic [R1W-1:0]          t2_n;
	logic [35:0]             p2;
	logic [R1W-1:0]          r2_full;
	logic [21:0]             p3;
	logic [10:0]             r3_full;
	logic [15:0]             p5;
	logic                    late;
	logic signed [YCW-1:0]   yr_n;
	logic signed [YCW-1:0]   yr_adj;

	// Advance the whole pipe unless the output holds an untaken result
	assign en        = !vld_q[NSTAGE-1] || rsp.ready;
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTAGE-2:0], req.valid};
		end
	end

	// Time of day runs in its own three stages, aligned with stage 3
	jdc_tod u_tod (
		.clk  (clk),
		.en   (en),
		.frac (req.day_fraction),
		.tod  (tod_s3)
	);

	// Stage 1: bias the day number into the 400-year frame
	assign mag   = req.day_number[DAY_BITS-2:0];
	assign pos_n = !req.day_number[DAY_BITS-1] && (mag != '0);

	// Stage 2: reciprocal estimates of the century and of the week count
	assign p1 = (T1W+Q1W)'(t1_s1) * (T1W+Q1W)'(M1);
	assign pw = (DAY_BITS+M7W)'(wx_s1) * (DAY_BITS+M7W)'(M7);

	// Stage 3: multiply back; weekday remainder still off by at most one week
	assign wr_full = wx_s2 - DAY_BITS'(wq_s2) * DAY_BITS'(WEEK_DAYS);

	// Stage 4: raw 400-year remainder, below 2 * DAYS_400Y
	assign r1_full = t1_s3 - prod1_s3;

	// Stage 6: year within the century, exact reciprocal
	assign t2_n = {r1_s5[R1W-1:2], 2'b11};
	assign p2   = 36'(t2_n) * 36'(M2);

	// Stage 7: remainder in the 4-year cycle
	assign r2_full = t2_s6 - R1W'(q2_s6) * R1W'(DAYS_4Y);

	// Stage 9: month counted from March
	assign p3 = 22'(t3_s8) * 22'(M3);

	// Stage 10: remainder within the 5-month block
	assign r3_full = t3_s9 - 11'(q3_s9) * 11'(DAYS_5M);

	// Stage 11: day of month, calendar month and year before the BC step
	assign p5   = 16'(r3_s10) * 16'(M5);
	assign late = (q3_s10 >= 4'(MONTH_WRAP));
	assign yr_n = $signed(YCW'(yb_s10)) + $signed(YCW'(late)) - $signed(YCW'(YEAR_SHIFT));

	// Stage 12: drop year zero for BC years
	assign yr_adj = (yr_s11[YCW-1] || (yr_s11 == '0)) ? yr_s11 - YCW'(1) : yr_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1
			pos_s1 <= pos_n;
			t1_s1  <= T1W'({mag, 2'b00}) + T1W'(T1_BIAS);
			wx_s1  <= DAY_BITS'(mag) + DAY_BITS'(1);
			// stage 2
			pos_s2 <= pos_s1;
			t1_s2  <= t1_s1;
			qe1_s2 <= p1[T1W +: Q1W];
			wx_s2  <= wx_s1;
			wq_s2  <= pw[DAY_BITS +: M7W];
			// stage 3
			pos_s3   <= pos_s2;
			t1_s3    <= t1_s2;
			qe1_s3   <= qe1_s2;
			prod1_s3 <= T1W'(qe1_s2) * T1W'(DAYS_400Y);
			wr_s3    <= wr_full[WRW-1:0];
			// stage 4
			qe1_s4           <= qe1_s3;
			r1raw_s4         <= r1_full[R1RAW_W-1:0];
			side_s4.pos      <= pos_s3;
			side_s4.weekday  <= (wr_s3 >= WRW'(WEEK_DAYS)) ?
				WDAY_W'(wr_s3 - WRW'(WEEK_DAYS)) : WDAY_W'(wr_s3);
			side_s4.tod      <= tod_s3;
			// stage 5: fix the century estimate
			if (r1raw_s4 >= R1RAW_W'(DAYS_400Y)) begin
				century_s5 <= qe1_s4 + Q1W'(1);
				r1_s5      <= R1W'(r1raw_s4 - R1RAW_W'(DAYS_400Y));
			end else begin
				century_s5 <= qe1_s4;
				r1_s5      <= R1W'(r1raw_s4);
			end
			side_s5 <= side_s4;
			// stage 6
			q2_s6   <= p2[K2 +: 7];
			t2_s6   <= t2_n;
			c100_s6 <= C100W'(century_s5) * C100W'(CENTURY_YEARS);
			side_s6 <= side_s5;
			// stage 7
			r2_s7   <= r2_full[10:0];
			yb_s7   <= c100_s6 + C100W'(q2_s6);
			side_s7 <= side_s6;
			// stage 8: five times the day of year, less three
			t3_s8   <= 11'(r2_s7[10:2]) * 11'(5) + 11'(2);
			yb_s8   <= yb_s7;
			side_s8 <= side_s7;
			// stage 9
			q3_s9   <= p3[K3 +: 4];
			t3_s9   <= t3_s8;
			yb_s9   <= yb_s8;
			side_s9 <= side_s8;
			// stage 10
			r3_s10   <= r3_full[7:0];
			q3_s10   <= q3_s9;
			yb_s10   <= yb_s9;
			side_s10 <= side_s9;
			// stage 11
			day_s11   <= MDAY_W'(p5[K5 +: MDAY_W]) + MDAY_W'(1);
			month_s11 <= late ? q3_s10 - 4'(MONTH_WRAP - 1) : q3_s10 + 4'(MARCH_FIRST);
			yr_s11    <= yr_n;
			side_s11  <= side_s10;
			// stage 12: output register, zero the result for a day number
			// that is not positive
			if (side_s11.pos) begin
				year_s12  <= yr_adj[YEAR_W-1:0];
				month_s12 <= month_s11;
				mday_s12  <= day_s11;
				wday_s12  <= side_s11.weekday;
				tod_s12   <= side_s11.tod;
			end else begin
				year_s12  <= '0;
				month_s12 <= '0;
				mday_s12  <= '0;
				wday_s12  <= '0;
				tod_s12   <= '0;
			end
		end
	end

	assign rsp.valid         = vld_q[NSTAGE-1];
	assign rsp.year          = year_s12;
	assign rsp.month         = month_s12;
	assign rsp.day_of_month  = mday_s12;
	assign rsp.weekday       = wday_s12;
	assign rsp.hour          = tod_s12.hour;
	assign rsp.minute        = tod_s12.minute;
	assign rsp.seconds_fixed = tod_s12.seconds_fixed;

	// A zero month marks a rejected day number, and then all else is zero
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.month == '0) |-> (rsp.year == '0) && (rsp.day_of_month == '0)
		&& (rsp.weekday == '0) && (rsp.hour == '0) && (rsp.minute == '0)
		&& (rsp.seconds_fixed == '0))
		else $error("rejected day number gave a non-zero field");

	// Valid results stay within calendar and clock ranges
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.month != '0) |-> (rsp.month <= 4'd12)
		&& (rsp.day_of_month != '0) && (rsp.weekday < WDAY_W'(WEEK_DAYS))
		&& (rsp.hour < HOUR_W'(HOURS)) && (rsp.minute < MINUTE_W'(MINUTES))
		&& (rsp.seconds_fixed <= SEC_W'(SEC_MAX)))
		else $error("result field out of range");

	// Century correction leaves a proper remainder
	a_century_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[4] |-> (r1_s5 < R1W'(DAYS_400Y)))
		else $error("400-year remainder not reduced");

	// Month estimate and its remainder agree
	a_month_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[9] |-> (r3_s10 < 8'(DAYS_5M)) && (q3_s10 <= 4'd11))
		else $error("month split out of range");

	// A stalled result holds off new requests
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |-> !req.ready)
		else $error("request taken while output stalled");

endmodule

[tb/sv/julian_day_to_calendar_tb.sv]
// Self-checking bench for the Julian day to calendar converter.
// Depends on jdc_pkg, jdc_req_if / jdc_rsp_if and julian_day_to_calendar.
`timescale 1ns / 100ps

module julian_day_to_calendar_tb;
	import jdc_pkg::*;

	localparam int PIPE_DEPTH  = 12;
	localparam int CYCLE_LIMIT = 200000;
	localparam int N_RANDOM    = 480;
	localparam int HOLD_AT     = 120;   // requests taken before the long response hold-off
	localparam int HOLD_CYCLES = 80;
	localparam int CALM_TAIL   = 100;   // final requests with no idling on either side

	typedef struct packed {
		year_t   year;
		month_t  month;
		mday_t   mday;
		wday_t   wday;
		hour_t   hour;
		minute_t minute;
		sec_t    secs;
	} calendar_t;

	typedef struct {
		day_num_t  day;
		day_frac_t frac;
		int        gap;      // idle cycles before this request is offered
		bit        drain;    // offer only once every result is back
	} stamp_t;

	logic clk;
	logic arst_n;

	jdc_req_if req_ch ();
	jdc_rsp_if rsp_ch ();

	julian_day_to_calendar uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	stamp_t    stamps_to_send[$];
	calendar_t dates_due[$];

	bit  req_fire;
	int  n_taken;
	int  n_checked;
	int  n_nonpos;
	int  n_total;
	int  n_errors;
	int  cycles;
	int  gap_left;
	bit  gap_armed;
	int  stall_left;
	bit  hold_done;
	bit  rsp_bursty;
	int  rsp_mode_left;
	longint year_lo;
	longint year_hi;

	// Convert a Julian day and day fraction into the expected calendar fields
	function automatic calendar_t calendar_of(day_num_t jd, day_frac_t frac);
		calendar_t   c;
		longint      n, t, cent, yr, doy, mon, dom;
		logic [63:0] p;
		c = '0;
		n = longint'(jd);
		if (n <= 0)
			return c;
		t    = (n + EPOCH_OFFSET) * 4 - 1;
		cent = t / DAYS_400Y;
		t    = ((t % DAYS_400Y) / 4) * 4 + 3;
		yr   = cent * CENTURY_YEARS + t / DAYS_4Y;
		doy  = (t % DAYS_4Y) / 4 + 1;
		t    = doy * 5 - 3;
		mon  = t / DAYS_5M;
		dom  = (t % DAYS_5M) / 5 + 1;
		// March-based year: January and February belong to the next one
		if (mon < 10) begin
			mon = mon + 3;
		end else begin
			yr  = yr + 1;
			mon = mon - 9;
		end
		yr = yr - YEAR_SHIFT;
		// no year zero: 0 becomes 1 BC
		if (yr <= 0)
			yr = yr - 1;
		c.year  = year_t'(yr);
		c.month = month_t'(mon);
		c.mday  = mday_t'(dom);
		c.wday  = wday_t'((n + 1) % WEEK_DAYS);
		// split the fraction: hours, then minutes, then Q16 seconds
		p        = 64'(frac) * HOURS;
		c.hour   = hour_t'(p >> FRAC_BITS);
		p        = 64'(p[FRAC_BITS-1:0]) * MINUTES;
		c.minute = minute_t'(p >> FRAC_BITS);
		p        = 64'(p[FRAC_BITS-1:0]) * MINUTES;
		c.secs   = sec_t'(p >> (FRAC_BITS - SEC_FRAC));
		return c;
	endfunction

	task automatic add_stamp(longint day, longint frac, int gap, bit drain);
		stamp_t s;
		s.day   = day_num_t'(day);
		s.frac  = day_frac_t'(frac);
		s.gap   = gap;
		s.drain = drain;
		stamps_to_send.push_back(s);
	endtask

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sample both channels: predict on each request, check each response
	always @(posedge clk) begin
		calendar_t want;
		calendar_t exp_date;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end else if (!arst_n) begin
			req_fire = 1'b0;
		end else begin
			req_fire = req_ch.valid && req_ch.ready;
			if (req_fire) begin
				want = calendar_of(req_ch.day_number, req_ch.day_fraction);
				dates_due.push_back(want);
				n_taken++;
				if (req_ch.day_number <= 0) begin
					n_nonpos++;
				end else begin
					if (longint'(want.year) < year_lo)
						year_lo = longint'(want.year);
					if (longint'(want.year) > year_hi)
						year_hi = longint'(want.year);
				end
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (dates_due.size() == 0) begin
					$error("response with no request outstanding");
					n_errors++;
				end else begin
					exp_date = dates_due.pop_front();
					n_checked++;
					check_field("year", longint'(exp_date.year), longint'(rsp_ch.year));
					check_field("month", exp_date.month, rsp_ch.month);
					check_field("day_of_month", exp_date.mday, rsp_ch.day_of_month);
					check_field("weekday", exp_date.wday, rsp_ch.weekday);
					check_field("hour", exp_date.hour, rsp_ch.hour);
					check_field("minute", exp_date.minute, rsp_ch.minute);
					check_field("seconds_fixed", exp_date.secs, rsp_ch.seconds_fixed);
				end
			end
		end
	end

	// Request driver: hold until taken, then advance after the item's idle gap
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!(req_ch.valid && !req_fire)) begin
			if (req_fire) begin
				void'(stamps_to_send.pop_front());
				gap_armed = 1'b0;
			end
			if (stamps_to_send.size() != 0 && !gap_armed) begin
				gap_left  = stamps_to_send[0].gap;
				gap_armed = 1'b1;
			end
			if (stamps_to_send.size() == 0) begin
				req_ch.valid <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				req_ch.valid <= 1'b0;
			end else if (stamps_to_send[0].drain && dates_due.size() != 0) begin
				req_ch.valid <= 1'b0;
			end else begin
				req_ch.valid        <= 1'b1;
				req_ch.day_number   <= stamps_to_send[0].day;
				req_ch.day_fraction <= stamps_to_send[0].frac;
			end
		end
	end

	// Response side: one long hold-off, random stalls in bursty stretches, none at the end
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_mode_left == 0) begin
				rsp_bursty    = $urandom_range(0, 2) != 0;
				rsp_mode_left = $urandom_range(100, 300);
			end else begin
				rsp_mode_left--;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!hold_done && n_taken >= HOLD_AT) begin
				hold_done  = 1'b1;
				stall_left = HOLD_CYCLES - 1;
				rsp_ch.ready <= 1'b0;
			end else if (rsp_bursty && n_taken < n_total - CALM_TAIL
					&& $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Stimulus, reset and verdict
	initial begin
		longint    dir_day[$];
		longint    dir_frac[$];
		longint    day, frac;
		bit        bursty;
		int        gap;
		longint    hour_edge, min_edge, sec_edge;

		req_ch.valid        = 1'b0;
		req_ch.day_number   = '0;
		req_ch.day_fraction = '0;
		rsp_ch.ready        = 1'b0;
		arst_n              = 1'b0;
		year_lo             = 64'sh7FFF_FFFF_FFFF_FFFF;
		year_hi             = -64'sh7FFF_FFFF_FFFF_FFFF;

		// smallest fractions that reach a full hour, minute and second
		hour_edge = ((64'd1 << FRAC_BITS) + HOURS - 1) / HOURS;
		min_edge  = ((64'd1 << FRAC_BITS) + HOURS * MINUTES - 1) / (HOURS * MINUTES);
		sec_edge  = ((64'd1 << FRAC_BITS) + HOURS * MINUTES * MINUTES - 1)
			/ (HOURS * MINUTES * MINUTES);

		// Directed: field extremes, non-positive days, era and leap edges, time edges
		dir_day  = {1, 0, -1, -16777216, 16777215, 16777215, 2451545, 2299160,
			2299161, 1721426, 1721425, 1721424, 1721424, 2451604, 2451605,
			2415079, 2415080, 1, 6, 2459945, 4000000, 10000000, -5};
		dir_frac = {0, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0,
			32'h8000_0000, 1, 32'hFFFF_FFFE, hour_edge, hour_edge - 1, min_edge,
			min_edge - 1, sec_edge, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_0000,
			32'h0000_FFFF, 12345, 32'hC000_0000, 32'h2000_0000, 32'h7FFF_FFFF, 0};
		foreach (dir_day[i])
			add_stamp(dir_day[i], dir_frac[i], (i % 5 == 4) ? 3 : 0, 1'b0);

		// Random: mostly positive days spread over eras, some non-positive
		bursty = 1'b1;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 40 == 0)
				bursty = $urandom_range(0, 2) != 0;
			// keep offering around the long hold-off and through the tail
			if ((i >= 80 && i < 220) || i >= N_RANDOM - CALM_TAIL)
				bursty = 1'b0;
			gap = (bursty && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
			case ($urandom_range(0, 9))
				0: day = longint'(day_num_t'($urandom));
				1: day = ($urandom_range(0, 3) == 0) ? -16777216
					: -longint'($urandom_range(0, 100000));
				2: day = $urandom_range(1, 400000);
				3, 4: day = $urandom_range(2299161, 2600000);
				5: day = $urandom_range(1721000, 1722000);
				default: day = $urandom_range(1, 16777215);
			endcase
			case ($urandom_range(0, 9))
				0: frac = 0;
				1: frac = 32'hFFFF_FFFF;
				2: frac = (64'($urandom_range(1, HOURS - 1)) * hour_edge)
					- $urandom_range(0, 1);
				default: frac = $urandom;
			endcase
			add_stamp(day, frac, gap, i == 0 || i == 300);
		end
		n_total = stamps_to_send.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every request to go out and every result to come back
		while (stamps_to_send.size() != 0 || dates_due.size() != 0)
			@(posedge clk);
		repeat (3 * PIPE_DEPTH) @(posedge clk);
		if (dates_due.size() != 0) begin
			$error("%0d results never arrived", dates_due.size());
			n_errors++;
		end

		$display("Converted %0d timestamps (%0d with day number not positive), %0d checked",
			n_taken, n_nonpos, n_checked);
		$display("Years seen from %0d to %0d, with stalls on both channels and a drain pause",
			year_lo, year_hi);
		if (n_errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
